### rtl/block_minmax_histogram_assert.svh
// Assertion macros for the brick statistics engine.
// Both forms sample on clk and are disabled while rst is high.
`ifndef BLOCK_MINMAX_HISTOGRAM_ASSERT_SVH
`define BLOCK_MINMAX_HISTOGRAM_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check cons in the same cycle as ante.
`define BMH_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brick statistics assertion failed");
// Check cons in the cycle after ante.
`define BMH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brick statistics assertion failed");
`else
`define BMH_ASSERT_SAME(lbl, ante, cons)
`define BMH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/bmh_pkg.sv
`timescale 1ns / 1ps
package bmh_pkg;

  // Operation codes carried on the input tuser
  typedef enum logic [1:0] {
    OP_CLEAR       = 2'd0,
    OP_ADD         = 2'd1,
    OP_READ_BIN    = 2'd2,
    OP_READ_MINMAX = 2'd3
  } opcode_t;

  localparam int BIN_COUNT = 256;
  localparam logic [7:0] VALUE_MAX = 8'hFF;
  localparam logic [6:0] PLANE_COUNT_RESET = 7'd64;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture an input beat
    logic lookup;     // register range checks
    logic commit;     // write back and load the result
    logic sweep;      // advance the clearing pass
    logic sweep_all;  // clearing pass covers min/max stores too
  } bmh_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_clear;        // captured item is a clear
    logic sweep_hist_last; // last histogram entry of the pass
    logic sweep_all_last;  // last entry of the full reset pass
    logic out_free;        // output register can take a result
  } bmh_stat_t;

endpackage

### rtl/bmh_ctrl.sv
`timescale 1ns / 1ps
module bmh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bmh_pkg::bmh_stat_t stat,
  output bmh_pkg::bmh_cmd_t  cmd
);
  import bmh_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOKUP,
    S_CLEAR,
    S_EXEC
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands and next state
  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        cmd.sweep_all = 1'b1;
        if (stat.sweep_all_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = in_valid && in_ready;
        if (in_valid && in_ready) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = stat.is_clear ? S_CLEAR : S_EXEC;
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_hist_last) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.commit = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // Hold state and the registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      in_ready <= 1'b0;
    end else begin
      state <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

### rtl/bmh_dp.sv
`timescale 1ns / 1ps
module bmh_dp #(
  parameter int PLANE_BRICKS = 64,
  parameter int TOTAL_BRICKS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  bmh_pkg::bmh_cmd_t  cmd,
  output bmh_pkg::bmh_stat_t stat,
  input  logic [25:0]        in_data,
  input  logic [1:0]         in_op,
  input  logic               cfg_write,
  input  logic [6:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_data,
  output logic               out_status
);
  import bmh_pkg::*;

  localparam int HIST_DEPTH  = PLANE_BRICKS * BIN_COUNT;
  localparam int HA          = $clog2(HIST_DEPTH);
  localparam int BA          = (TOTAL_BRICKS > 1) ? $clog2(TOTAL_BRICKS) : 1;
  localparam int SWEEP_DEPTH = (HIST_DEPTH > TOTAL_BRICKS) ? HIST_DEPTH : TOTAL_BRICKS;
  localparam int CW          = $clog2(SWEEP_DEPTH);

  logic [6:0]  plane_count;
  opcode_t     fld_op;
  logic [7:0]  fld_value;
  logic [5:0]  fld_plane;
  logic [3:0]  fld_depth;
  logic [7:0]  fld_bin;

  logic [16:0]   brick_wide;
  logic [16:0]   hist_wide;
  logic [BA-1:0] brick_addr;
  logic [HA-1:0] hist_addr;
  logic          plane_ok_comb;
  logic          brick_ok_comb;
  logic          plane_ok;
  logic          brick_ok;

  logic [CW-1:0] sweep_cnt;
  logic          hist_in_range;
  logic          mm_in_range;

  logic [15:0] hist_mem [HIST_DEPTH];
  logic [15:0] mm_mem [TOTAL_BRICKS];
  logic [15:0] hist_rd;
  logic [15:0] mm_rd;
  logic          hist_we;
  logic [HA-1:0] hist_waddr;
  logic [15:0]   hist_wdata;
  logic          mm_we;
  logic [BA-1:0] mm_waddr;
  logic [15:0]   mm_wdata;
  logic [7:0]    new_min;
  logic [7:0]    new_max;
  logic          do_add;

  logic [15:0] res_count;
  logic [7:0]  res_min;
  logic [7:0]  res_max;
  logic        res_status;

  // Hold the brick count register
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count <= PLANE_COUNT_RESET;
    end else if (cfg_write) begin
      plane_count <= cfg_data;
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fld_op    <= opcode_t'(in_op);
      fld_value <= in_data[7:0];
      fld_plane <= in_data[13:8];
      fld_depth <= in_data[17:14];
      fld_bin   <= in_data[25:18];
    end
  end

  // Form addresses and range checks
  always_comb begin
    brick_wide = ({13'd0, fld_depth} * {10'd0, plane_count}) + {11'd0, fld_plane};
    hist_wide = {3'd0, fld_plane, (fld_op == OP_ADD) ? fld_value : fld_bin};
    brick_addr = brick_wide[BA-1:0];
    hist_addr = hist_wide[HA-1:0];
    plane_ok_comb = ({1'b0, fld_plane} < plane_count) && (32'(fld_plane) < PLANE_BRICKS);
    brick_ok_comb = plane_ok_comb && (32'(brick_wide) < TOTAL_BRICKS);
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      plane_ok <= plane_ok_comb;
      brick_ok <= brick_ok_comb;
    end
  end

  // Advance the clearing pass, wrap at the end of its range
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      if (cmd.sweep_all ? stat.sweep_all_last : stat.sweep_hist_last) begin
        sweep_cnt <= '0;
      end else begin
        sweep_cnt <= sweep_cnt + CW'(1);
      end
    end
  end

  assign hist_in_range = 32'(sweep_cnt) < HIST_DEPTH;
  assign mm_in_range = 32'(sweep_cnt) < TOTAL_BRICKS;

  // Merge the voxel into the brick bounds
  assign new_min = (fld_value < mm_rd[7:0]) ? fld_value : mm_rd[7:0];
  assign new_max = (fld_value > mm_rd[15:8]) ? fld_value : mm_rd[15:8];
  assign do_add = cmd.commit && (fld_op == OP_ADD) && brick_ok;

  always_comb begin
    if (cmd.sweep) begin
      hist_we = hist_in_range;
      hist_waddr = sweep_cnt[HA-1:0];
      hist_wdata = '0;
      mm_we = cmd.sweep_all && mm_in_range;
      mm_waddr = sweep_cnt[BA-1:0];
      mm_wdata = {8'h00, VALUE_MAX};
    end else begin
      hist_we = do_add;
      hist_waddr = hist_addr;
      hist_wdata = hist_rd + 16'd1;
      mm_we = do_add;
      mm_waddr = brick_addr;
      mm_wdata = {new_max, new_min};
    end
  end

  // Histogram store
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rd <= hist_mem[hist_addr];
  end

  // Min/max store, max in the upper byte
  always_ff @(posedge clk) begin
    if (mm_we) mm_mem[mm_waddr] <= mm_wdata;
    mm_rd <= mm_mem[brick_addr];
  end

  // Build the result fields
  always_comb begin
    res_count = '0;
    res_min = '0;
    res_max = '0;
    res_status = 1'b0;
    case (fld_op)
      OP_CLEAR: res_status = 1'b0;
      OP_ADD: res_status = !brick_ok;
      OP_READ_BIN: begin
        if (plane_ok) res_count = hist_rd;
        else res_status = 1'b1;
      end
      OP_READ_MINMAX: begin
        if (brick_ok) begin
          res_min = mm_rd[7:0];
          res_max = mm_rd[15:8];
        end else begin
          res_status = 1'b1;
        end
      end
      default: res_status = 1'b0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {res_max, res_min, res_count};
      out_status <= res_status;
    end
  end

  assign stat.is_clear = (fld_op == OP_CLEAR);
  assign stat.sweep_hist_last = (32'(sweep_cnt) == HIST_DEPTH - 1);
  assign stat.sweep_all_last = (32'(sweep_cnt) == SWEEP_DEPTH - 1);
  assign stat.out_free = !out_valid || out_ready;

endmodule

### rtl/block_minmax_histogram.sv
`timescale 1ns / 1ps
`include "block_minmax_histogram_assert.svh"
// Brick statistics engine: per-brick 256-bin histograms for the current slab
// and running min/max for every brick of the volume, one result beat per input
// beat. After reset the block runs a clearing pass over max(PLANE_BRICKS*256,
// TOTAL_BRICKS) entries (16384 at the defaults) with s_axis_tready low. Add
// and read items pass through capture, memory lookup and write-back, set by
// the read-modify-write of the histogram and min/max memories with their
// registered reads; a clear item sweeps the histogram memory one entry a
// cycle. A finished result waits in the output register while the next beat
// is accepted. Configuration writes are always taken and must only happen
// while the block is idle.
module block_minmax_histogram #(
  parameter int PLANE_BRICKS = 64,
  parameter int TOTAL_BRICKS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // voxel_value[7:0], plane_brick[13:8], depth_brick[17:14], bin_index[25:18]
  input  logic [31:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bin_count[15:0], min_value[23:16], max_value[31:24]
  output logic [31:0] m_axis_tdata,
  // status[0]
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  import bmh_pkg::*;

  bmh_cmd_t  cmd;
  bmh_stat_t stat;

  assign cfg_ready = 1'b1;

  bmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmh_dp #(
    .PLANE_BRICKS (PLANE_BRICKS),
    .TOTAL_BRICKS (TOTAL_BRICKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (s_axis_tdata[25:0]),
    .in_op      (s_axis_tuser),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_status (m_axis_tuser[0])
  );

  // One item in flight: no beat is taken right after an accepted one
  `BMH_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // Flagged results carry all-zero data
  `BMH_ASSERT_SAME(a_flag_zero_data, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'd0)
  // No input is taken during a clearing pass
  `BMH_ASSERT_SAME(a_sweep_blocks_input, cmd.sweep, !s_axis_tready)

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import bmh_pkg::*;

  localparam int PLANES      = 64;
  localparam int BRICKS      = 1024;
  localparam int HIST_SIZE   = PLANES * BIN_COUNT;
  localparam int STALL_LIMIT = 100000;
  localparam int LONG_HOLD   = 400;
  localparam int BURST_ADDS  = 16;
  localparam int DRAIN_WAIT  = 20;

  // One input beat, split into its fields
  typedef struct packed {
    opcode_t    op;
    logic [7:0] voxel;
    logic [5:0] plane;
    logic [3:0] depth;
    logic [7:0] bin;
  } voxel_op_t;

  // One result beat
  typedef struct packed {
    logic [15:0] count;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        flag;
  } brick_stat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // voxel_value[7:0], plane_brick[13:8], depth_brick[17:14], bin_index[25:18]
  logic [31:0] s_axis_tdata = '0;
  // opcode[1:0]
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // bin_count[15:0], min_value[23:16], max_value[31:24]
  logic [31:0] m_axis_tdata;
  // status[0]
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  // Shadow copy of the brick statistics
  logic [7:0]  shadow_min [BRICKS];
  logic [7:0]  shadow_max [BRICKS];
  logic [15:0] shadow_hist [HIST_SIZE];
  logic [6:0]  shadow_plane_count;

  voxel_op_t   pending_ops [$];
  brick_stat_t expected_stats [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_wanted = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  int ops_queued = 0;
  int ops_accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int flagged_results = 0;
  int cfg_writes = 0;
  int n_clear = 0;
  int n_add = 0;
  int n_read_bin = 0;
  int n_read_minmax = 0;

  block_minmax_histogram i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the shadow stores and return the result it yields
  function automatic brick_stat_t apply_brick_op(voxel_op_t it);
    brick_stat_t r;
    int brick;
    bit plane_ok;
    bit brick_ok;
    r = '0;
    brick = int'(it.depth) * int'(shadow_plane_count) + int'(it.plane);
    plane_ok = (it.plane < shadow_plane_count) && (int'(it.plane) < PLANES);
    brick_ok = plane_ok && (brick < BRICKS);
    case (it.op)
      OP_CLEAR: begin
        for (int i = 0; i < HIST_SIZE; i++) shadow_hist[i] = '0;
      end
      OP_ADD: begin
        if (brick_ok) begin
          shadow_hist[{it.plane, it.voxel}] = shadow_hist[{it.plane, it.voxel}] + 16'd1;
          if (it.voxel < shadow_min[brick]) shadow_min[brick] = it.voxel;
          if (it.voxel > shadow_max[brick]) shadow_max[brick] = it.voxel;
        end else begin
          r.flag = 1'b1;
        end
      end
      OP_READ_BIN: begin
        if (plane_ok) r.count = shadow_hist[{it.plane, it.bin}];
        else r.flag = 1'b1;
      end
      default: begin
        if (brick_ok) begin
          r.lo = shadow_min[brick];
          r.hi = shadow_max[brick];
        end else begin
          r.flag = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Random operation, focused on a few bricks and values so reads hit live counts
  function automatic voxel_op_t random_voxel_op();
    voxel_op_t it;
    int unsigned pick;
    it.voxel = 8'($urandom_range(255));
    it.plane = 6'($urandom_range(63));
    it.depth = 4'($urandom_range(15));
    it.bin   = 8'($urandom_range(255));
    pick = $urandom_range(999);
    if (pick < 8) it.op = OP_CLEAR;
    else if (pick < 550) it.op = OP_ADD;
    else if (pick < 780) it.op = OP_READ_BIN;
    else it.op = OP_READ_MINMAX;
    if ($urandom_range(99) < 60) it.plane = 6'($urandom_range(3));
    if ($urandom_range(99) < 60) it.depth = 4'($urandom_range(2));
    if ($urandom_range(99) < 50) it.voxel = 8'($urandom_range(3) * 85);
    if ($urandom_range(99) < 50) it.bin = 8'($urandom_range(3) * 85);
    return it;
  endfunction

  task automatic push_op(input opcode_t op, input logic [7:0] voxel, input logic [5:0] plane,
                         input logic [3:0] depth, input logic [7:0] bin);
    voxel_op_t it;
    it = '{op: op, voxel: voxel, plane: plane, depth: depth, bin: bin};
    pending_ops.push_back(it);
    ops_queued++;
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) begin
      pending_ops.push_back(random_voxel_op());
      ops_queued++;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 40)
      $display("tb: mismatch on result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic wait_drained();
    while (ops_accepted != ops_queued || expected_stats.size() != 0) @(posedge clk);
  endtask

  // Let the block settle, write a new plane count, then set the idle mix
  task automatic next_setting(input logic [6:0] value, input int send_pct, input int recv_pct);
    wait_drained();
    repeat (8) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Drive input beats; hold each beat until it is taken
  always @(posedge clk) begin : driver
    voxel_op_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, nxt.bin, nxt.depth, nxt.plane, nxt.voxel};
        s_axis_tuser  <= nxt.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: random stalls, plus one long hold-off to back up the block
  always @(posedge clk) begin : receiver
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_wanted && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check result beats first, then predict for the input beat of this edge
  always @(posedge clk) begin : monitor
    brick_stat_t got;
    brick_stat_t want;
    voxel_op_t   beat;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        shadow_plane_count = cfg_data;
        cfg_writes++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tdata[31:24], m_axis_tuser[0]};
        results_seen++;
        if (got.flag) flagged_results++;
        if (expected_stats.size() == 0) begin
          report_mismatch("result with nothing pending, bin_count", got.count, 0);
        end else begin
          want = expected_stats.pop_front();
          if (got.count != want.count) report_mismatch("bin_count", got.count, want.count);
          if (got.lo != want.lo) report_mismatch("min_value", got.lo, want.lo);
          if (got.hi != want.hi) report_mismatch("max_value", got.hi, want.hi);
          if (got.flag != want.flag) report_mismatch("status", got.flag, want.flag);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beat.op    = opcode_t'(s_axis_tuser);
        beat.voxel = s_axis_tdata[7:0];
        beat.plane = s_axis_tdata[13:8];
        beat.depth = s_axis_tdata[17:14];
        beat.bin   = s_axis_tdata[25:18];
        expected_stats.push_back(apply_brick_op(beat));
        ops_accepted++;
        case (beat.op)
          OP_CLEAR:    n_clear++;
          OP_ADD:      n_add++;
          OP_READ_BIN: n_read_bin++;
          default:     n_read_minmax++;
        endcase
      end
    end
  end

  // Abort when no beat moves for too long
  always @(posedge clk) begin : watchdog
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: no beat moved for %0d cycles", STALL_LIMIT);
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    for (int i = 0; i < BRICKS; i++) begin
      shadow_min[i] = VALUE_MAX;
      shadow_max[i] = '0;
    end
    for (int i = 0; i < HIST_SIZE; i++) shadow_hist[i] = '0;
    shadow_plane_count = PLANE_COUNT_RESET;
    send_idle_pct = 35;
    recv_idle_pct = 61;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset plane count: reset contents, back-to-back adds to one bin, far corner brick
    push_op(OP_READ_BIN,    8'h00, 6'd0,  4'd0,  8'h00);
    push_op(OP_READ_MINMAX, 8'hFF, 6'd0,  4'd0,  8'hFF);
    push_op(OP_ADD,         8'h00, 6'd0,  4'd0,  8'hFF);
    push_op(OP_ADD,         8'h00, 6'd0,  4'd0,  8'h00);
    push_op(OP_ADD,         8'hFF, 6'd0,  4'd0,  8'h00);
    push_op(OP_READ_BIN,    8'hAA, 6'd0,  4'd15, 8'h00);
    push_op(OP_READ_BIN,    8'h55, 6'd0,  4'd0,  8'hFF);
    push_op(OP_READ_MINMAX, 8'h00, 6'd0,  4'd0,  8'h00);
    push_op(OP_ADD,         8'h80, 6'd63, 4'd15, 8'h00);
    push_op(OP_READ_MINMAX, 8'h00, 6'd63, 4'd15, 8'h00);
    push_op(OP_READ_BIN,    8'h00, 6'd63, 4'd15, 8'h80);
    push_op(OP_ADD,         8'hFF, 6'd63, 4'd15, 8'h00);
    push_op(OP_ADD,         8'h01, 6'd63, 4'd15, 8'h00);
    push_op(OP_READ_MINMAX, 8'h00, 6'd63, 4'd15, 8'h00);
    // Clear ignores all other fields and keeps min/max
    push_op(OP_CLEAR,       8'hFF, 6'd63, 4'd15, 8'hFF);
    push_op(OP_READ_BIN,    8'h00, 6'd0,  4'd0,  8'h00);
    push_op(OP_READ_MINMAX, 8'h00, 6'd0,  4'd0,  8'h00);
    push_random(400);

    // Single brick per slab: plane 1 out of range
    next_setting(7'd1, 35, 61);
    push_op(OP_ADD,         8'h10, 6'd1,  4'd0,  8'h00);
    push_op(OP_READ_BIN,    8'h00, 6'd1,  4'd0,  8'h10);
    push_op(OP_ADD,         8'h10, 6'd0,  4'd15, 8'h00);
    push_op(OP_READ_MINMAX, 8'h00, 6'd0,  4'd15, 8'h00);
    push_random(200);

    // Zero plane count flags every add and read
    next_setting(7'd0, 61, 35);
    push_random(60);

    // Oversized plane count: brick index runs past the store
    next_setting(7'd127, 61, 35);
    push_op(OP_READ_MINMAX, 8'h00, 6'd63, 4'd15, 8'h00);
    push_op(OP_READ_BIN,    8'h00, 6'd63, 4'd15, 8'h00);
    push_op(OP_ADD,         8'h42, 6'd0,  4'd8,  8'h00);
    push_op(OP_ADD,         8'h42, 6'd8,  4'd8,  8'h00);
    push_random(300);

    // No random idling; one long output hold-off
    next_setting(7'd17, 0, 0);
    hold_wanted = 1'b1;
    push_random(300);

    // Back to the full slab, then a burst of adds to one bin
    next_setting(7'd64, 0, 0);
    push_random(300);
    push_op(OP_CLEAR, 8'h00, 6'd0, 4'd0, 8'h00);
    for (int i = 0; i < BURST_ADDS; i++)
      push_op(OP_ADD, 8'd77, 6'd5, 4'd3, 8'($urandom_range(255)));
    push_op(OP_READ_BIN,    8'h00, 6'd5, 4'd3, 8'd77);
    push_op(OP_READ_MINMAX, 8'h00, 6'd5, 4'd3, 8'd77);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("tb: %0d beats in (%0d adds, %0d bin reads, %0d min/max reads, %0d clears)",
             ops_accepted, n_add, n_read_bin, n_read_minmax, n_clear);
    $display("tb: %0d results checked, %0d flagged out of range, %0d plane count writes",
             results_seen, flagged_results, cfg_writes);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/bmh_pkg.sv
rtl/bmh_ctrl.sv
rtl/bmh_dp.sv
rtl/block_minmax_histogram.sv
tb/sv/tb.sv
